[hdl/word_crc8_frame_checker_assert.svh]
// Assertion macros for the word CRC-8 frame checker.
// Included by the top level; no other dependencies.
`ifndef WORD_CRC8_FRAME_CHECKER_ASSERT_SVH
`define WORD_CRC8_FRAME_CHECKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WCFC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define WCFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WCFC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define WCFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/wcfc_pkg.sv]
// Shared types and constants for the word CRC-8 frame checker.
// No dependencies.
`default_nettype none
package wcfc_pkg;

  localparam logic [7:0] CRC_START_RESET = 8'hFF;
  localparam logic [7:0] CRC_POLY_RESET  = 8'h31;
  localparam logic [7:0] INDEX_MAX       = 8'hFF;

  localparam logic REG_CRC_START = 1'b0;
  localparam logic REG_CRC_POLY  = 1'b1;

  localparam logic [1:0] STATUS_MATCH    = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TRUNC    = 2'd2;

  typedef enum logic [2:0] {
    POS_HIGH  = 3'b001,
    POS_LOW   = 3'b010,
    POS_CHECK = 3'b100
  } byte_pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic [1:0]  word_status;
    logic [7:0]  computed_crc;
    logic [7:0]  word_index;
    logic        frame_good;
    logic        last_word;
  } word_result_t;

  typedef struct packed {
    logic [7:0] crc_start_value;
    logic [7:0] crc_polynomial;
  } crc_cfg_t;

endpackage
`default_nettype wire

[hdl/wcfc_ifs.sv]
// Valid/ready channel interfaces: byte input and word result.
// Depends on nothing.
`default_nettype none
interface wcfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface wcfc_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [1:0]  word_status;
  logic [7:0]  computed_crc;
  logic [7:0]  word_index;
  logic        frame_good;
  logic        last_word;
  modport source (output valid, output word_value, output word_status,
                  output computed_crc, output word_index, output frame_good,
                  output last_word, input ready);
  modport sink (input valid, input word_value, input word_status,
                input computed_crc, input word_index, input frame_good,
                input last_word, output ready);
endinterface
`default_nettype wire

[hdl/wcfc_crc_step.sv]
// One-byte CRC-8 update, MSB first, unrolled over the eight bits.
// Pure combinational; no package use.
`default_nettype none
module wcfc_crc_step (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  input  wire logic [7:0] poly,
  output logic      [7:0] crc_out
);

  always_comb begin
    logic [7:0] r;
    r = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    crc_out = r;
  end

endmodule
`default_nettype wire

[hdl/wcfc_in_stage.sv]
// Input register for the byte channel; holds one request while the
// check stage stalls. Depends on wcfc_pkg and wcfc_byte_if.
`default_nettype none
module wcfc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  wcfc_byte_if.sink               byte_in,
  input  wire logic               advance,
  output logic                    item_valid,
  output wcfc_pkg::byte_item_t    item
);

  logic take;

  assign byte_in.ready = !item_valid || advance;
  assign take = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (byte_in.ready) begin
      item_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data_byte <= byte_in.data_byte;
      item.frame_end <= byte_in.frame_end;
    end
  end

endmodule
`default_nettype wire

[hdl/wcfc_check_stage.sv]
// Framing state, CRC accumulation and the result register.
// Depends on wcfc_pkg, wcfc_crc_step and wcfc_word_if.
`default_nettype none
module wcfc_check_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wcfc_pkg::crc_cfg_t cfg,
  input  wire logic               item_valid,
  input  wire wcfc_pkg::byte_item_t item,
  output logic                    advance,
  wcfc_word_if.source             word_out
);

  wcfc_pkg::byte_pos_t    pos, pos_next;
  logic [7:0]             crc_acc, crc_acc_next;
  logic [7:0]             high_hold, high_hold_next;
  logic [7:0]             low_hold, low_hold_next;
  logic [7:0]             words_seen, words_seen_next;
  logic                   all_good, all_good_next;
  logic                   out_valid;
  wcfc_pkg::word_result_t result, result_next;
  logic                   has_result;
  logic [7:0]             crc_in, crc_new;
  logic                   match;

  assign crc_in = (pos == wcfc_pkg::POS_HIGH) ? cfg.crc_start_value : crc_acc;

  wcfc_crc_step u_crc (
    .crc_in  (crc_in),
    .data_in (item.data_byte),
    .poly    (cfg.crc_polynomial),
    .crc_out (crc_new)
  );

  assign match      = (crc_acc == item.data_byte);
  assign has_result = item.frame_end || (pos == wcfc_pkg::POS_CHECK);
  assign advance    = item_valid && (!has_result || !out_valid || word_out.ready);

  always_comb begin
    pos_next        = pos;
    crc_acc_next    = crc_acc;
    high_hold_next  = high_hold;
    low_hold_next   = low_hold;
    words_seen_next = words_seen;
    all_good_next   = all_good;
    result_next.word_value   = {high_hold, low_hold};
    result_next.word_status  = wcfc_pkg::STATUS_TRUNC;
    result_next.computed_crc = 8'h00;
    result_next.word_index   = words_seen;
    result_next.frame_good   = 1'b0;
    result_next.last_word    = 1'b1;
    case (pos)
      wcfc_pkg::POS_HIGH: begin
        high_hold_next = item.data_byte;
        low_hold_next  = 8'h00;
        crc_acc_next   = crc_new;
        pos_next       = wcfc_pkg::POS_LOW;
        result_next.word_value = {item.data_byte, 8'h00};
      end
      wcfc_pkg::POS_LOW: begin
        low_hold_next  = item.data_byte;
        crc_acc_next   = crc_new;
        pos_next       = wcfc_pkg::POS_CHECK;
        result_next.word_value = {high_hold, item.data_byte};
      end
      default: begin
        result_next.word_status  = match ? wcfc_pkg::STATUS_MATCH
                                         : wcfc_pkg::STATUS_MISMATCH;
        result_next.computed_crc = crc_acc;
        result_next.frame_good   = all_good && match;
        result_next.last_word    = item.frame_end;
        all_good_next            = all_good && match;
        if (words_seen != wcfc_pkg::INDEX_MAX) begin
          words_seen_next = words_seen + 8'd1;
        end
        pos_next = wcfc_pkg::POS_HIGH;
      end
    endcase
    if (item.frame_end) begin
      pos_next        = wcfc_pkg::POS_HIGH;
      words_seen_next = 8'h00;
      all_good_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= wcfc_pkg::POS_HIGH;
      words_seen <= 8'h00;
      all_good   <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        pos        <= pos_next;
        words_seen <= words_seen_next;
        all_good   <= all_good_next;
      end
      if (advance && has_result) begin
        out_valid <= 1'b1;
      end else if (word_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_acc   <= crc_acc_next;
      high_hold <= high_hold_next;
      low_hold  <= low_hold_next;
    end
    if (advance && has_result) begin
      result <= result_next;
    end
  end

  assign word_out.valid        = out_valid;
  assign word_out.word_value   = result.word_value;
  assign word_out.word_status  = result.word_status;
  assign word_out.computed_crc = result.computed_crc;
  assign word_out.word_index   = result.word_index;
  assign word_out.frame_good   = result.frame_good;
  assign word_out.last_word    = result.last_word;

endmodule
`default_nettype wire

[hdl/word_crc8_frame_checker.sv]
// Top level of the word CRC-8 frame checker: configuration registers,
// input register and check stage. Depends on wcfc_pkg, wcfc_ifs,
// wcfc_in_stage, wcfc_check_stage and word_crc8_frame_checker_assert.svh.
//
//   channel   dir  payload                                       request
//   byte_in   in   data_byte, frame_end                          one byte
//   word_out  out  word_value, word_status, computed_crc,        one result
//                  word_index, frame_good, last_word
//   write_*   in   write_index, write_data                       one register
//
// One byte per cycle while byte_in.ready is high; a closing byte goes to the
// input register, then its result to the result register after the CRC update.
// Reset (rst, synchronous) clears framing and loads 0xFF / 0x31.
// A stalled result holds the check stage only at the next byte that closes a
// word or frame; data bytes keep flowing, and byte_in.ready drops while that
// byte waits in the input register.
`default_nettype none
`include "word_crc8_frame_checker_assert.svh"
module word_crc8_frame_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  wcfc_byte_if.sink       byte_in,
  wcfc_word_if.source     word_out,
  input  wire logic       write_en,
  input  wire logic       write_index,
  input  wire logic [7:0] write_data
);

  wcfc_pkg::crc_cfg_t  cfg;
  logic                item_valid;
  wcfc_pkg::byte_item_t item;
  logic                advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_start_value <= wcfc_pkg::CRC_START_RESET;
      cfg.crc_polynomial  <= wcfc_pkg::CRC_POLY_RESET;
    end else if (write_en) begin
      case (write_index)
        wcfc_pkg::REG_CRC_START: cfg.crc_start_value <= write_data;
        wcfc_pkg::REG_CRC_POLY:  cfg.crc_polynomial  <= write_data;
        default: ;
      endcase
    end
  end

  wcfc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wcfc_check_stage u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .word_out   (word_out)
  );

  `WCFC_ASSERT_ALWAYS(a_trunc_closes, clk, rst,
    !(word_out.valid && word_out.word_status == wcfc_pkg::STATUS_TRUNC) ||
    (word_out.last_word && !word_out.frame_good), "truncated word must close frame")
  `WCFC_ASSERT_ALWAYS(a_mismatch_bad, clk, rst,
    !(word_out.valid && word_out.word_status == wcfc_pkg::STATUS_MISMATCH) ||
    !word_out.frame_good, "mismatch reported with frame good")
  `WCFC_ASSERT_NEXT(a_stall_keeps_byte, clk, rst, item_valid && !advance,
    item_valid, "held byte dropped during stall")

endmodule
`default_nettype wire
